// ===== src/ppsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsc_pkg
// Types, limits and helpers shared by the packed pattern stream checker.
// ----------------------------------------------------------------------------
package ppsc_pkg;

  localparam int unsigned MAX_CHANNELS = 32;
  localparam int unsigned MAX_ROWS     = 256;

  localparam int unsigned CH_W     = 6;   // channel count / index width
  localparam int unsigned ROW_W    = 9;   // row count / index width
  localparam int unsigned TOTAL_W  = 14;  // cells started counter
  localparam int unsigned SKIP_W   = 3;   // bytes still owed to a cell
  localparam int unsigned FROW_W   = 8;   // reported fail row
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CH_W-1:0]   CH_MAX_SAT  = CH_W'(MAX_CHANNELS);
  localparam logic [ROW_W-1:0]  ROW_MAX_SAT = ROW_W'(MAX_ROWS);
  localparam logic [CH_W-1:0]   CH_RESET    = CH_W'(1);
  localparam logic [ROW_W-1:0]  ROW_RESET   = ROW_W'(64);

  localparam int unsigned       FLAG_BIT      = 7;  // compressed cell marker
  localparam int unsigned       MASK_BITS     = 5;  // bits 0..4 flag extra bytes
  localparam logic [SKIP_W-1:0] PLAIN_EXTRA   = SKIP_W'(4);

  // register select is paddr[2]: one 32-bit register per word
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT     = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic               verdict;
    logic [FROW_W-1:0]  fail_row;
    logic [TOTAL_W-1:0] cells_started;
  } out_beat_t;

  function automatic logic [SKIP_W-1:0] extra_bytes(input logic [7:0] b);
    logic [SKIP_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_BITS; i++) begin
      n = n + SKIP_W'(b[i]);
    end
    return n;
  endfunction

endpackage

// ===== src/packed_pattern_stream_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pattern_stream_checker_unit
// Walks a pattern's packed cell bytes and reports one verdict per pattern.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except that a last byte stalls while an untaken
// result waits; the cell tracker updates in the accept cycle. The result is registered.
// Non-last bytes keep flowing while a result waits in the output register.
// Reset (rst_n low, synchronous): tracker and out_valid cleared, channel_count
// returns to 1 and row_count to 64.
module packed_pattern_stream_checker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ppsc_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ppsc_pkg::out_beat_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppsc_pkg::APB_AW-1:0]      paddr,
  input  logic [ppsc_pkg::APB_DW-1:0]      pwdata,
  output logic [ppsc_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned CH_W    = ppsc_pkg::CH_W;
  localparam int unsigned ROW_W   = ppsc_pkg::ROW_W;
  localparam int unsigned TOTAL_W = ppsc_pkg::TOTAL_W;
  localparam int unsigned SKIP_W  = ppsc_pkg::SKIP_W;
  localparam int unsigned FROW_W  = ppsc_pkg::FROW_W;

  // configuration
  logic [CH_W-1:0]  chan_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic             cfg_wr;

  // cell tracker
  logic [SKIP_W-1:0]  skip_r,  skip_nxt;
  logic               comp_r,  comp_nxt;
  logic [CH_W-1:0]    ch_r,    ch_nxt;
  logic [ROW_W-1:0]   row_r,   row_nxt;
  logic               seen_r,  seen_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic                out_valid_r;
  ppsc_pkg::out_beat_t out_data_r, result;

  logic [CH_W-1:0]  eff_ch;
  logic [ROW_W-1:0] eff_rows;
  logic             none_left, none_left_nxt;
  logic [CH_W:0]    ch_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] frow_full;
  logic             in_acc, out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == ppsc_pkg::REG_CHANNEL_COUNT) begin
      prdata = ppsc_pkg::APB_DW'(chan_cnt_r);
    end else begin
      prdata = ppsc_pkg::APB_DW'(row_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= ppsc_pkg::CH_RESET;
      row_cnt_r  <= ppsc_pkg::ROW_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ppsc_pkg::REG_CHANNEL_COUNT) begin
        chan_cnt_r <= pwdata[CH_W-1:0];
      end else begin
        row_cnt_r <= pwdata[ROW_W-1:0];
      end
    end
  end

  assign eff_ch   = (chan_cnt_r > ppsc_pkg::CH_MAX_SAT) ? ppsc_pkg::CH_MAX_SAT : chan_cnt_r;
  assign eff_rows = (row_cnt_r > ppsc_pkg::ROW_MAX_SAT) ? ppsc_pkg::ROW_MAX_SAT : row_cnt_r;

  // a result register that is free or draining this cycle can take a new one;
  // bytes that produce no result never wait on the output side
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = out_free || !in_data.last_byte;
  assign in_acc   = in_valid && in_ready;

  assign none_left = seen_r || (eff_ch == '0) || (eff_rows == '0) || (row_r >= eff_rows);
  assign ch_inc    = {1'b0, ch_r} + 1'b1;
  assign row_inc   = {1'b0, row_r} + 1'b1;

  always_comb begin
    skip_nxt  = skip_r;
    comp_nxt  = comp_r;
    ch_nxt    = ch_r;
    row_nxt   = row_r;
    seen_nxt  = seen_r;
    total_nxt = total_r;
    if (skip_r != '0) begin
      skip_nxt = skip_r - 1'b1;
    end else if (!none_left) begin
      comp_nxt  = in_data.data_byte[ppsc_pkg::FLAG_BIT];
      skip_nxt  = comp_nxt ? ppsc_pkg::extra_bytes(in_data.data_byte)
                           : ppsc_pkg::PLAIN_EXTRA;
      total_nxt = total_r + 1'b1;
      if (ch_inc >= {1'b0, eff_ch}) begin
        ch_nxt  = '0;
        row_nxt = row_inc[ROW_W-1:0];
        if (row_inc >= {1'b0, eff_rows}) begin
          seen_nxt = 1'b1;
        end
      end else begin
        ch_nxt = ch_inc[CH_W-1:0];
      end
    end
  end

  assign none_left_nxt = seen_nxt || (eff_ch == '0) || (eff_rows == '0) ||
                         (row_nxt >= eff_rows);

  // a compressed cell still owed bytes: report the row it started in
  assign frow_full = (ch_nxt == '0) ? row_nxt - 1'b1 : row_nxt;

  always_comb begin
    result.verdict       = 1'b0;
    result.fail_row      = '0;
    result.cells_started = total_nxt;
    if (comp_nxt && (skip_nxt != '0)) begin
      result.verdict  = 1'b1;
      result.fail_row = frow_full[FROW_W-1:0];
    end else if (!none_left_nxt) begin
      result.verdict  = 1'b1;
      result.fail_row = row_nxt[FROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      comp_r  <= 1'b0;
      ch_r    <= '0;
      row_r   <= '0;
      seen_r  <= 1'b0;
      total_r <= '0;
    end else if (in_acc) begin
      if (in_data.last_byte) begin
        skip_r  <= '0;
        comp_r  <= 1'b0;
        ch_r    <= '0;
        row_r   <= '0;
        seen_r  <= 1'b0;
        total_r <= '0;
      end else begin
        skip_r  <= skip_nxt;
        comp_r  <= comp_nxt;
        ch_r    <= ch_nxt;
        row_r   <= row_nxt;
        seen_r  <= seen_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_acc && in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_acc && in_data.last_byte) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/ppsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsc_checker
// Port-level checks for the packed pattern stream checker, bound to the top.
// ----------------------------------------------------------------------------
module ppsc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input ppsc_pkg::in_beat_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input ppsc_pkg::out_beat_t         out_data,
  input logic                        pready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // sound verdict reports row zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.verdict |-> out_data.fail_row == '0)
    else $error("fail_row set on sound pattern");

  // every accepted last beat yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> out_valid)
    else $error("missing result after last beat");

  // a non-last beat into a free output produces nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last_byte && !(out_valid && !out_ready)
    |=> !out_valid)
    else $error("result without last beat");

  assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind packed_pattern_stream_checker_unit ppsc_checker u_ppsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

// ===== verif/ppsc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsc_verdict_checker
// Watches the byte, verdict and register channels of the packed pattern
// stream checker, tracks the cell walk of each pattern on its own and
// compares every verdict beat, field by field, with the predicted one.
// ----------------------------------------------------------------------------
module ppsc_verdict_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  ppsc_pkg::in_beat_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  ppsc_pkg::out_beat_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ppsc_pkg::APB_AW-1:0] paddr,
  input  logic [ppsc_pkg::APB_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending,
  output int                          bytes_seen,
  output int                          verdicts_seen,
  output int                          corrupt_seen
);

  // register shadow
  logic [ppsc_pkg::CH_W-1:0]    chan_cfg;
  logic [ppsc_pkg::ROW_W-1:0]   rows_cfg;

  // cell walk of the current pattern
  logic [ppsc_pkg::SKIP_W-1:0]  owed;
  logic                         compr;
  logic [ppsc_pkg::CH_W-1:0]    chan_pos;
  logic [ppsc_pkg::ROW_W-1:0]   row_pos;
  logic                         all_seen;
  logic [ppsc_pkg::TOTAL_W-1:0] started;

  ppsc_pkg::out_beat_t verdict_q[$];
  int                  errs, n_bytes, n_verdicts, n_corrupt;

  function automatic int unsigned chan_lim(input logic [ppsc_pkg::CH_W-1:0] c);
    return (c > ppsc_pkg::MAX_CHANNELS) ? ppsc_pkg::MAX_CHANNELS : int'(c);
  endfunction

  function automatic int unsigned rows_lim(input logic [ppsc_pkg::ROW_W-1:0] r);
    return (r > ppsc_pkg::MAX_ROWS) ? ppsc_pkg::MAX_ROWS : int'(r);
  endfunction

  function automatic bit walk_done();
    return all_seen || chan_lim(chan_cfg) == 0 || rows_lim(rows_cfg) == 0 ||
           row_pos >= rows_lim(rows_cfg);
  endfunction

  task automatic clear_walk();
    owed     = '0;
    compr    = 1'b0;
    chan_pos = '0;
    row_pos  = '0;
    all_seen = 1'b0;
    started  = '0;
  endtask

  // advance the cell walk by one byte; a last byte yields a verdict
  task automatic track_byte(input ppsc_pkg::in_beat_t b);
    int                  ch_next, row_next, frow;
    ppsc_pkg::out_beat_t v;
    if (owed != 0) begin
      owed = owed - 1'b1;
    end else if (!walk_done()) begin
      if (b.data_byte[ppsc_pkg::FLAG_BIT]) begin
        compr = 1'b1;
        owed  = ppsc_pkg::SKIP_W'($countones(b.data_byte[4:0]));
      end else begin
        compr = 1'b0;
        owed  = ppsc_pkg::SKIP_W'(4);
      end
      started  = started + 1'b1;
      ch_next  = int'(chan_pos) + 1;
      row_next = int'(row_pos);
      if (ch_next >= chan_lim(chan_cfg)) begin
        ch_next  = 0;
        row_next = row_next + 1;
        if (row_next >= rows_lim(rows_cfg)) all_seen = 1'b1;
      end
      chan_pos = ch_next[ppsc_pkg::CH_W-1:0];
      row_pos  = row_next[ppsc_pkg::ROW_W-1:0];
    end
    if (b.last_byte) begin
      v.verdict = 1'b0;
      frow      = 0;
      if (compr && owed != 0) begin
        // compressed cell runs past the end: blame the row it started in
        v.verdict = 1'b1;
        frow      = (chan_pos == 0) ? int'(row_pos) - 1 : int'(row_pos);
      end else if (!walk_done()) begin
        v.verdict = 1'b1;
        frow      = int'(row_pos);
      end
      v.fail_row      = frow[ppsc_pkg::FROW_W-1:0];
      v.cells_started = started;
      verdict_q.push_back(v);
      clear_walk();
    end
  endtask

  always @(posedge clk) begin
    ppsc_pkg::out_beat_t want;
    if (!rst_n) begin
      chan_cfg = ppsc_pkg::CH_RESET;
      rows_cfg = ppsc_pkg::ROW_RESET;
      clear_walk();
      verdict_q.delete();
      errs       = 0;
      n_bytes    = 0;
      n_verdicts = 0;
      n_corrupt  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ppsc_pkg::REG_CHANNEL_COUNT) chan_cfg = pwdata[ppsc_pkg::CH_W-1:0];
        else                                         rows_cfg = pwdata[ppsc_pkg::ROW_W-1:0];
      end
      if (in_valid && in_ready) begin
        n_bytes++;
        track_byte(in_data);
      end
      if (out_valid && out_ready) begin
        n_verdicts++;
        if (verdict_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected verdict beat, expected none, actual %h", $realtime,
                   out_data);
        end else begin
          want = verdict_q.pop_front();
          if (want.verdict) n_corrupt++;
          if (out_data.verdict !== want.verdict) begin
            errs++;
            $display("%0t: verdict expected %0d actual %0d", $realtime, want.verdict,
                     out_data.verdict);
          end
          if (out_data.fail_row !== want.fail_row) begin
            errs++;
            $display("%0t: fail_row expected %0d actual %0d", $realtime, want.fail_row,
                     out_data.fail_row);
          end
          if (out_data.cells_started !== want.cells_started) begin
            errs++;
            $display("%0t: cells_started expected %0d actual %0d", $realtime,
                     want.cells_started, out_data.cells_started);
          end
        end
      end
    end
    fail_count    <= errs;
    pending       <= verdict_q.size();
    bytes_seen    <= n_bytes;
    verdicts_seen <= n_verdicts;
    corrupt_seen  <= n_corrupt;
  end

endmodule

// ===== verif/tb_packed_pattern_stream_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_pattern_stream_checker_unit
// Drives packed pattern byte streams (clean, padded, truncated and noise)
// through the stream checker under changing channel and row counts, with
// random stalls on both channels; the verdict checker scores every beat.
// ----------------------------------------------------------------------------
module tb_packed_pattern_stream_checker_unit;

  localparam int LIMIT = 400000;
  localparam logic [ppsc_pkg::APB_AW-1:0] ADDR_CHANNELS =
    {ppsc_pkg::REG_CHANNEL_COUNT, 2'b00};
  localparam logic [ppsc_pkg::APB_AW-1:0] ADDR_ROWS = {ppsc_pkg::REG_ROW_COUNT, 2'b00};

  typedef enum int { PAT_CLEAN, PAT_TRAIL, PAT_CUT, PAT_NOISE } pat_kind_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  ppsc_pkg::in_beat_t          in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  ppsc_pkg::out_beat_t         out_data;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ppsc_pkg::APB_AW-1:0] paddr = '0;
  logic [ppsc_pkg::APB_DW-1:0] pwdata = '0;
  logic [ppsc_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  int fail_count, pending, bytes_seen, verdicts_seen, corrupt_seen;
  int cycles = 0;
  int sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  logic [7:0] pat_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  packed_pattern_stream_checker_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ppsc_verdict_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_seen   (bytes_seen),
    .verdicts_seen(verdicts_seen),
    .corrupt_seen (corrupt_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure in bursts; none in the closing stretch
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [ppsc_pkg::APB_AW-1:0] a,
                           input logic [ppsc_pkg::APB_DW-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: l};
    do @(posedge clk); while (!in_ready);
    sent++;
    if (sent >= 700) calm = 1'b1;
  endtask

  task automatic send_pattern(input bit with_last);
    for (int i = 0; i < pat_q.size(); i++) begin
      push_byte(pat_q[i], with_last && (i == pat_q.size() - 1));
    end
  endtask

  // drop valid and let every verdict drain
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic build_pattern(input int cells, input pat_kind_t kind, input bit dense,
                               input int cap);
    logic [7:0] start;
    int         extra, cut;
    pat_q.delete();
    if (kind == PAT_NOISE) begin
      repeat ($urandom_range(1, 12)) pat_q.push_back(8'($urandom));
      return;
    end
    for (int c = 0; c < cells && pat_q.size() < cap; c++) begin
      if (dense && $urandom_range(0, 3) != 0)
        start = {1'b1, 2'($urandom), 5'b0};
      else
        start = 8'($urandom_range(0, 255));
      pat_q.push_back(start);
      extra = start[ppsc_pkg::FLAG_BIT] ? $countones(start[4:0])
                                        : int'(ppsc_pkg::PLAIN_EXTRA);
      repeat (extra) pat_q.push_back(8'($urandom));
    end
    if (kind == PAT_TRAIL) begin
      repeat ($urandom_range(1, 4)) pat_q.push_back(8'($urandom));
    end else if (kind == PAT_CUT && pat_q.size() > 1) begin
      cut = $urandom_range(1, (pat_q.size() - 1 < 6) ? pat_q.size() - 1 : 6);
      repeat (cut) void'(pat_q.pop_back());
    end
    if (pat_q.size() == 0) pat_q.push_back(8'($urandom));
  endtask

  task automatic set_counts(input logic [ppsc_pkg::CH_W-1:0] ch,
                            input logic [ppsc_pkg::ROW_W-1:0] rows);
    logic [ppsc_pkg::APB_DW-1:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : '0;
    reg_write(ADDR_CHANNELS, {junk[ppsc_pkg::APB_DW-1:ppsc_pkg::CH_W], ch});
    junk = $urandom_range(0, 1) ? $urandom : '0;
    reg_write(ADDR_ROWS, {junk[ppsc_pkg::APB_DW-1:ppsc_pkg::ROW_W], rows});
  endtask

  initial begin
    int          phase, npat, cells, cap, pick;
    logic [5:0]  ch;
    logic [8:0]  rows;
    bit          dense;
    pat_kind_t   kind;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset counts (1 x 64): short stream leaves cells missing
    pat_q = '{8'h80, 8'h80, 8'h80};
    send_pattern(1);
    drain();

    set_counts(6'd2, 9'd2);
    pat_q = '{8'h80, 8'h80, 8'h80, 8'h80};               // exact fit
    send_pattern(1);
    pat_q = '{8'h80, 8'h80, 8'h80, 8'h7F};               // plain final cell overruns
    send_pattern(1);
    pat_q = '{8'h80, 8'h80};                             // cells missing
    send_pattern(1);
    pat_q = '{8'h80, 8'h80, 8'h80, 8'h9F};               // compressed final overruns
    send_pattern(1);
    pat_q = '{8'h81, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h80, 8'h80, 8'h55};                      // trailing byte ignored
    send_pattern(1);
    drain();

    set_counts(6'd0, 9'd3);                              // no cells needed
    pat_q = '{8'hAA};
    send_pattern(1);
    drain();

    set_counts(6'd63, 9'd511);                           // both saturate
    pat_q = '{8'h80, 8'h80, 8'h80};
    send_pattern(1);
    drain();

    phase = 0;
    while (sent < 800) begin
      dense = ($urandom_range(0, 2) == 0);
      cap   = 120;
      case (phase)
        1: begin ch = 6'd1;  rows = 9'd256; cap = 1000; dense = 1'b1; end
        2: begin ch = 6'd63; rows = 9'd511; cap = 30; end
        8: begin ch = 6'd32; rows = 9'd2;   dense = 1'b1; end
        11: begin ch = 6'd0; rows = 9'($urandom_range(1, 4)); end
        12: begin ch = 6'($urandom_range(1, 4)); rows = 9'd0; end
        default: begin
          ch   = ($urandom_range(0, 11) == 0) ? 6'd0 : 6'($urandom_range(1, 4));
          rows = ($urandom_range(0, 11) == 0) ? 9'd0 : 9'($urandom_range(1, 4));
        end
      endcase
      set_counts(ch, rows);
      cells = ((ch > ppsc_pkg::MAX_CHANNELS) ? ppsc_pkg::MAX_CHANNELS : ch) *
              ((rows > ppsc_pkg::MAX_ROWS) ? ppsc_pkg::MAX_ROWS : rows);
      npat = (phase == 1) ? 1 : $urandom_range(2, 6);
      for (int p = 0; p < npat; p++) begin
        pick = $urandom_range(0, 19);
        kind = (pick < 8) ? PAT_CLEAN : (pick < 12) ? PAT_TRAIL :
               (pick < 17) ? PAT_CUT : PAT_NOISE;
        build_pattern(cells, kind, dense, cap);
        send_pattern(1);
        // in phase 3, after the first pattern, the sender holds until every verdict is back
        if (phase == 3 && p == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          wait (pending == 0);
        end
      end
      // sometimes leave a pattern open across the next register change
      if ($urandom_range(0, 3) == 0) begin
        build_pattern(cells, PAT_CUT, dense, 12);
        send_pattern(0);
      end
      drain();
      phase++;
    end

    // close any open pattern under the final counts
    pat_q = '{8'($urandom)};
    send_pattern(1);
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes over %0d count settings, %0d verdicts (%0d corrupt)",
             bytes_seen, phase + 4, verdicts_seen, corrupt_seen);
    $display("clean, padded, truncated, overrun and noise streams with stalls on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ppsc_pkg.sv
src/packed_pattern_stream_checker_unit.sv
src/ppsc_checker.sv
verif/ppsc_verdict_checker.sv
verif/tb_packed_pattern_stream_checker_unit.sv
